/* sv/lcr_pkg.sv */
// Shared types and constants of the bridge converter serial reader.
// Used by the channel interfaces and every module of the block; no dependencies.
package lcr_pkg;

    // Word and averaging sizes
    localparam int DATA_BITS       = 24;
    localparam int MAX_AVERAGE     = 256;
    localparam int MAX_EXTRA       = 4;
    localparam int SUM_BITS        = DATA_BITS + $clog2(MAX_AVERAGE);
    localparam int CNT_W           = $clog2(MAX_AVERAGE + 1);
    localparam int PULSE_W         = $clog2(DATA_BITS + MAX_EXTRA + 1);
    localparam int DIV_CNT_W       = $clog2(SUM_BITS);

    // Register field widths
    localparam int GAIN_W          = 2;
    localparam int WAIT_W          = 24;
    localparam int HP_W            = 8;

    // Configuration port
    localparam int ADDR_W          = 5;
    localparam int APB_DW          = 32;
    localparam int REG_IDX_W       = ADDR_W - 2;

    localparam logic [WAIT_W-1:0] TIMEOUT_RST = WAIT_W'(200000);

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_GAIN    = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_COUNT   = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_HALF    = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_PDOWN   = REG_IDX_W'(4);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_LOAD,
        PH_DIV
    } t_phase;

    // Effective configuration (count and half period already clamped)
    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [CNT_W-1:0]  count;
        logic [WAIT_W-1:0] timeout;
        logic [HP_W-1:0]   half_period;
        logic              power_down;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic run_clear;
        logic wait_clear;
        logic wait_inc;
        logic read_clear;
        logic hp_inc;
        logic hp_clear;
        logic shift_en;
        logic pulse_inc;
        logic acc;
        logic div_start;
        logic avg_store;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic wait_expire;
        logic hp_reached;
        logic bit_slot;
        logic more_pulses;
        logic last_reading;
        logic div_fin;
    } t_stat;

    // Control fields of one result beat
    typedef struct packed {
        logic load;
        logic clk;
        logic busy;
        logic done;
        logic tmo;
    } t_beat;

    function automatic logic signed [SUM_BITS-1:0] sext(input logic [DATA_BITS-1:0] w);
        sext = {{(SUM_BITS - DATA_BITS){w[DATA_BITS-1]}}, w};
    endfunction

endpackage

/* sv/lcr_ifs.sv */
// Valid/ready channel interfaces for tick inputs and per-tick results.
// Depends on lcr_pkg.
interface lcr_in_if;
    import lcr_pkg::*;

    logic valid;
    logic ready;
    logic dout_sample;
    logic start_req;

    modport source (output valid, output dout_sample, output start_req, input ready);
    modport sink   (input valid, input dout_sample, input start_req, output ready);
endinterface

interface lcr_out_if;
    import lcr_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        clock_out;
    logic                        busy_res;
    logic                        done_res;
    logic                        timed_out;
    logic signed [DATA_BITS-1:0] average;

    modport source (output valid, output clock_out, output busy_res, output done_res,
                    output timed_out, output average, input ready);
    modport sink   (input valid, input clock_out, input busy_res, input done_res,
                    input timed_out, input average, output ready);
endinterface

/* sv/load_cell_adc_serial_reader_top.sv */
// Top level of the bridge converter serial reader: channels, registers, sequencer
// and datapath. Depends on lcr_pkg, lcr_ifs, lcr_regs, lcr_ctrl and lcr_dpath.
//
// Each input beat is one time tick carrying the sampled data line and a start
// request; each accepted beat yields exactly one result beat, in order, through a
// one-deep output register. A tick is taken in any cycle in which that register is
// empty or its beat leaves, so with a ready receiver one tick is accepted per clock.
// The exception is the tick that completes the last reading of a request: its
// result comes out only once the divider is loaded, the one-bit-per-cycle
// restoring divider has formed sum / count and the average is stored, and once
// the receiver has taken the previous beat; no tick is taken meanwhile.
// Registers sit at byte addresses 0, 4, 8, 12 and 16 and are to be written only
// while no run is active; the block itself does not enforce this.
module load_cell_adc_serial_reader_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lcr_in_if.sink                      i_item,
    lcr_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcr_pkg::ADDR_W-1:0]  paddr,
    input  logic [lcr_pkg::APB_DW-1:0]  pwdata,
    output logic [lcr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import lcr_pkg::*;

    t_cfg                 cfg;
    t_cmd                 cmd;
    t_stat                stat;
    t_beat                beat;
    logic                 in_ready;
    logic                 out_free;
    logic [DATA_BITS-1:0] avg_next;

    logic                 r_out_valid;
    logic                 r_clk;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_tmo;
    logic [DATA_BITS-1:0] r_avg;

    assign out_free     = !r_out_valid || o_res.ready;
    assign i_item.ready = in_ready;

    lcr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_dout     (i_item.dout_sample),
        .i_start    (i_item.start_req),
        .i_out_free (out_free),
        .i_pdown    (cfg.power_down),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .o_beat     (beat)
    );

    lcr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .i_dout     (i_item.dout_sample),
        .o_stat     (stat),
        .o_avg_next (avg_next)
    );

    // Output register: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (beat.load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge i_clk) begin
        if (beat.load) begin
            r_clk  <= beat.clk;
            r_busy <= beat.busy;
            r_done <= beat.done;
            r_tmo  <= beat.tmo;
            r_avg  <= avg_next;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.clock_out = r_clk;
    assign o_res.busy_res  = r_busy;
    assign o_res.done_res  = r_done;
    assign o_res.timed_out = r_tmo;
    assign o_res.average   = r_avg;

    // A result beat is only formed when the output register has room
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat.load |-> out_free)
        else $error("result beat overwrites a pending beat");

endmodule

/* sv/lcr_regs.sv */
// APB-style configuration registers with read-back and clamped effective values.
// Depends on lcr_pkg.
module lcr_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcr_pkg::ADDR_W-1:0]  paddr,
    input  logic [lcr_pkg::APB_DW-1:0]  pwdata,
    output logic [lcr_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output lcr_pkg::t_cfg               o_cfg
);
    import lcr_pkg::*;

    logic [GAIN_W-1:0]    r_gain;
    logic [CNT_W-1:0]     r_count;
    logic [WAIT_W-1:0]    r_timeout;
    logic [HP_W-1:0]      r_half;
    logic                 r_pdown;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain    <= '0;
            r_count   <= CNT_W'(1);
            r_timeout <= TIMEOUT_RST;
            r_half    <= HP_W'(1);
            r_pdown   <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_GAIN:    r_gain    <= pwdata[GAIN_W-1:0];
                REG_COUNT:   r_count   <= pwdata[CNT_W-1:0];
                REG_TIMEOUT: r_timeout <= pwdata[WAIT_W-1:0];
                REG_HALF:    r_half    <= pwdata[HP_W-1:0];
                REG_PDOWN:   r_pdown   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_GAIN:    prdata = APB_DW'(r_gain);
            REG_COUNT:   prdata = APB_DW'(r_count);
            REG_TIMEOUT: prdata = APB_DW'(r_timeout);
            REG_HALF:    prdata = APB_DW'(r_half);
            REG_PDOWN:   prdata = APB_DW'(r_pdown);
            default:     prdata = '0;
        endcase
    end

    // Effective values: count clamped to 1..MAX_AVERAGE, zero half period acts as one
    always_comb begin
        o_cfg.gain        = r_gain;
        o_cfg.timeout     = r_timeout;
        o_cfg.power_down  = r_pdown;
        o_cfg.half_period = (r_half == '0) ? HP_W'(1) : r_half;
        if (r_count == '0) begin
            o_cfg.count = CNT_W'(1);
        end else if (r_count > CNT_W'(MAX_AVERAGE)) begin
            o_cfg.count = CNT_W'(MAX_AVERAGE);
        end else begin
            o_cfg.count = r_count;
        end
    end

endmodule

/* sv/lcr_ctrl.sv */
// Readout sequencer: phase state machine, input handshake and per-tick result control.
// Depends on lcr_pkg; drives lcr_dpath through t_cmd and reads t_stat.
module lcr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_dout,
    input  logic            i_start,
    input  logic            i_out_free,
    input  logic            i_pdown,
    input  lcr_pkg::t_stat  i_stat,
    output logic            o_in_ready,
    output lcr_pkg::t_cmd   o_cmd,
    output lcr_pkg::t_beat  o_beat
);
    import lcr_pkg::*;

    t_phase r_state;
    t_phase n_state;
    logic   fire;

    // No tick is taken while the average is being worked out
    assign o_in_ready = (r_state != PH_LOAD) && (r_state != PH_DIV) && i_out_free;
    assign fire       = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next phase, datapath commands and result beat
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_beat  = '0;
        if (fire) begin
            o_beat.load = 1'b1;
            if (i_pdown) begin
                n_state    = PH_IDLE;
                o_beat.clk = 1'b1;
            end else begin
                case (r_state)
                    PH_IDLE: begin
                        if (i_start) begin
                            o_cmd.run_clear  = 1'b1;
                            o_cmd.wait_clear = 1'b1;
                            n_state          = PH_WAIT;
                        end
                    end
                    PH_WAIT: begin
                        if (!i_dout) begin
                            o_cmd.read_clear = 1'b1;
                            n_state          = PH_HIGH;
                        end else begin
                            o_cmd.wait_inc = 1'b1;
                            if (i_stat.wait_expire) begin
                                n_state    = PH_IDLE;
                                o_beat.tmo = 1'b1;
                            end
                        end
                    end
                    PH_HIGH: begin
                        o_beat.clk = 1'b1;
                        if (i_stat.hp_reached) begin
                            o_cmd.hp_clear = 1'b1;
                            o_cmd.shift_en = i_stat.bit_slot;
                            n_state        = PH_LOW;
                        end else begin
                            o_cmd.hp_inc = 1'b1;
                        end
                    end
                    PH_LOW: begin
                        if (i_stat.hp_reached) begin
                            o_cmd.hp_clear  = 1'b1;
                            o_cmd.pulse_inc = 1'b1;
                            if (i_stat.more_pulses) begin
                                n_state = PH_HIGH;
                            end else begin
                                o_cmd.acc = 1'b1;
                                if (i_stat.last_reading) begin
                                    // result beat waits for the divider
                                    o_beat.load = 1'b0;
                                    n_state     = PH_LOAD;
                                end else begin
                                    o_cmd.wait_clear = 1'b1;
                                    n_state          = PH_WAIT;
                                end
                            end
                        end else begin
                            o_cmd.hp_inc = 1'b1;
                        end
                    end
                    default: n_state = PH_IDLE;
                endcase
            end
        end else begin
            case (r_state)
                PH_LOAD: begin
                    o_cmd.div_start = 1'b1;
                    n_state         = PH_DIV;
                end
                PH_DIV: begin
                    // done beat also waits for room in the output register
                    if (i_stat.div_fin && i_out_free) begin
                        o_cmd.avg_store = 1'b1;
                        o_beat.load     = 1'b1;
                        o_beat.done     = 1'b1;
                        n_state         = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
        o_beat.busy = (n_state != PH_IDLE);
    end

    // A finished run and a timeout never share a beat
    a_done_tmo_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_beat.load |-> !(o_beat.done && o_beat.tmo))
        else $error("done and timeout in one beat");

    // The averaged result closes the run with the clock low
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_beat.load && o_beat.done) |-> (!o_beat.busy && !o_beat.clk))
        else $error("done beat while busy or clock high");

endmodule

/* sv/lcr_dpath.sv */
// Readout datapath: tick counters, shift register, running sum, serial divider.
// Depends on lcr_pkg; controlled by lcr_ctrl through t_cmd / t_stat.
module lcr_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lcr_pkg::t_cfg                  i_cfg,
    input  lcr_pkg::t_cmd                  i_cmd,
    input  logic                           i_dout,
    output lcr_pkg::t_stat                 o_stat,
    output logic [lcr_pkg::DATA_BITS-1:0]  o_avg_next
);
    import lcr_pkg::*;

    logic [WAIT_W-1:0]          r_wait;
    logic [HP_W-1:0]            r_hpc;
    logic [PULSE_W-1:0]         r_pulse;
    logic [DATA_BITS-1:0]       r_shift;
    logic signed [SUM_BITS-1:0] r_sum;
    logic [CNT_W-1:0]           r_reads;
    logic [DATA_BITS-1:0]       r_last_avg;
    logic [SUM_BITS-1:0]        r_quo;
    logic [CNT_W-1:0]           r_rem;
    logic                       r_neg;
    logic [DIV_CNT_W-1:0]       r_div_cnt;
    logic                       r_div_run;
    logic                       r_div_fin;

    logic [PULSE_W:0]           pulse_limit;
    logic [CNT_W:0]             trial;
    logic [CNT_W-1:0]           rem_shift;
    logic [DATA_BITS-1:0]       quo_low;

    // Status compares, all but bit_slot against the counter's next value
    assign pulse_limit        = (PULSE_W+1)'(DATA_BITS + 1) + (PULSE_W+1)'(i_cfg.gain);
    assign o_stat.wait_expire = ({1'b0, r_wait} + (WAIT_W+1)'(1)) >= {1'b0, i_cfg.timeout};
    assign o_stat.hp_reached  = ({1'b0, r_hpc} + (HP_W+1)'(1)) >= {1'b0, i_cfg.half_period};
    assign o_stat.bit_slot    = r_pulse < PULSE_W'(DATA_BITS);
    assign o_stat.more_pulses = ({1'b0, r_pulse} + (PULSE_W+1)'(1)) < pulse_limit;
    assign o_stat.last_reading = ({1'b0, r_reads} + (CNT_W+1)'(1)) >= {1'b0, i_cfg.count};
    assign o_stat.div_fin     = r_div_fin;

    // One restoring step: remainder stays below the count
    assign rem_shift = {r_rem[CNT_W-2:0], r_quo[SUM_BITS-1]};
    assign trial     = {r_rem, r_quo[SUM_BITS-1]} - {1'b0, i_cfg.count};

    // Truncation toward zero: divide magnitudes, restore the sign
    assign quo_low    = r_quo[DATA_BITS-1:0];
    assign o_avg_next = i_cmd.avg_store ? (r_neg ? (~quo_low + DATA_BITS'(1)) : quo_low)
                                        : r_last_avg;

    // Tick counters and bit capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait  <= '0;
            r_hpc   <= '0;
            r_pulse <= '0;
            r_reads <= '0;
        end else begin
            if (i_cmd.wait_clear) begin
                r_wait <= '0;
            end else if (i_cmd.wait_inc) begin
                r_wait <= r_wait + WAIT_W'(1);
            end
            if (i_cmd.read_clear || i_cmd.hp_clear) begin
                r_hpc <= '0;
            end else if (i_cmd.hp_inc) begin
                r_hpc <= r_hpc + HP_W'(1);
            end
            if (i_cmd.read_clear) begin
                r_pulse <= '0;
            end else if (i_cmd.pulse_inc) begin
                r_pulse <= r_pulse + PULSE_W'(1);
            end
            if (i_cmd.run_clear) begin
                r_reads <= '0;
            end else if (i_cmd.acc) begin
                r_reads <= r_reads + CNT_W'(1);
            end
        end
    end

    // Shift register and running sum
    always_ff @(posedge i_clk) begin
        if (i_cmd.read_clear) begin
            r_shift <= '0;
        end else if (i_cmd.shift_en) begin
            r_shift <= {r_shift[DATA_BITS-2:0], i_dout};
        end
        if (i_cmd.run_clear) begin
            r_sum <= '0;
        end else if (i_cmd.acc) begin
            r_sum <= r_sum + sext(r_shift);
        end
    end

    // Serial divider control and stored average
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run  <= 1'b0;
            r_div_fin  <= 1'b0;
            r_div_cnt  <= '0;
            r_last_avg <= '0;
        end else begin
            r_last_avg <= o_avg_next;
            if (i_cmd.div_start) begin
                r_div_run <= 1'b1;
                r_div_fin <= 1'b0;
                r_div_cnt <= '0;
            end else if (r_div_run) begin
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                if (r_div_cnt == DIV_CNT_W'(SUM_BITS - 1)) begin
                    r_div_run <= 1'b0;
                    r_div_fin <= 1'b1;
                end
            end else if (i_cmd.avg_store) begin
                r_div_fin <= 1'b0;
            end
        end
    end

    // Divider operands: one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= r_sum[SUM_BITS-1];
            r_quo <= r_sum[SUM_BITS-1] ? (~r_sum + SUM_BITS'(1)) : r_sum;
            r_rem <= '0;
        end else if (r_div_run) begin
            if (!trial[CNT_W]) begin
                r_rem <= trial[CNT_W-1:0];
                r_quo <= {r_quo[SUM_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_shift;
                r_quo <= {r_quo[SUM_BITS-2:0], 1'b0};
            end
        end
    end

    // Partial remainder must stay below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_run && !$past(i_cmd.div_start) |-> (r_rem < i_cfg.count))
        else $error("divider remainder out of range");

endmodule

/* tb/sv/load_cell_adc_serial_reader_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the bridge converter serial reader top level.
// Drives tick beats and APB register writes, predicts every result beat with its own
// tick-level model of the reader; depends on lcr_pkg, lcr_ifs and the block's RTL.
module load_cell_adc_serial_reader_top_tb;
    import lcr_pkg::*;

    localparam int CLK_HALF_NS  = 2;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int ITEM_TARGET  = 1700;

    // One result beat as the reader should produce it
    typedef struct packed {
        logic                 clk;
        logic                 busy;
        logic                 done;
        logic                 tmo;
        logic [DATA_BITS-1:0] avg;
    } t_tick_res;

    typedef enum {RX_ALWAYS, RX_HALF, RX_PATTERN, RX_MOSTLY} t_rx_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    lcr_in_if  tick_ch ();
    lcr_out_if res_ch ();

    load_cell_adc_serial_reader_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (tick_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Reader model: registers and state
    logic [GAIN_W-1:0]    m_gain;
    logic [CNT_W-1:0]     m_count;
    logic [WAIT_W-1:0]    m_timeout;
    logic [HP_W-1:0]      m_half;
    logic                 m_pdown;
    t_phase               m_phase;
    int unsigned          m_pulses;
    int unsigned          m_hp_cnt;
    int unsigned          m_wait_cnt;
    logic [DATA_BITS-1:0] m_word;
    longint               m_sum;
    int unsigned          m_reads;
    logic [DATA_BITS-1:0] m_avg;

    // Expected result beats, oldest first
    t_tick_res            pending_beats[$];
    // Words the converter should present next, ahead of random ones
    logic [DATA_BITS-1:0] word_plan[$];
    logic [DATA_BITS-1:0] conv_word;
    int                   wait_left;
    int                   burst_left;
    int                   sent_items;
    int                   errors;
    int                   cycle_cnt;
    bit                   hold_req;

    initial i_clk = 1'b0;
    always #(CLK_HALF_NS) i_clk = ~i_clk;

    function automatic void reset_reader_model();
        m_gain     = '0;
        m_count    = CNT_W'(1);
        m_timeout  = TIMEOUT_RST;
        m_half     = HP_W'(1);
        m_pdown    = 1'b0;
        m_phase    = PH_IDLE;
        m_pulses   = 0;
        m_hp_cnt   = 0;
        m_wait_cnt = 0;
        m_word     = '0;
        m_sum      = 0;
        m_reads    = 0;
        m_avg      = '0;
    endfunction

    // Advance the reader by one tick and return the beat it produces
    function automatic t_tick_res serial_reader_tick(input logic dout, input logic start);
        t_tick_res   r;
        int unsigned hp;
        int unsigned n;
        longint      quot;
        r  = '0;
        hp = (m_half == '0) ? 1 : m_half;
        if (m_pdown) begin
            m_phase = PH_IDLE;
            r.clk   = 1'b1;
        end else begin
            case (m_phase)
                PH_IDLE: begin
                    if (start) begin
                        m_sum      = 0;
                        m_reads    = 0;
                        m_wait_cnt = 0;
                        m_phase    = PH_WAIT;
                    end
                end
                PH_WAIT: begin
                    if (!dout) begin
                        m_phase  = PH_HIGH;
                        m_pulses = 0;
                        m_hp_cnt = 0;
                        m_word   = '0;
                    end else begin
                        m_wait_cnt++;
                        if (m_wait_cnt >= m_timeout) begin
                            m_phase = PH_IDLE;
                            r.tmo   = 1'b1;
                        end
                    end
                end
                PH_HIGH: begin
                    r.clk = 1'b1;
                    m_hp_cnt++;
                    if (m_hp_cnt >= hp) begin
                        m_hp_cnt = 0;
                        if (m_pulses < DATA_BITS)
                            m_word = {m_word[DATA_BITS-2:0], dout};
                        m_phase = PH_LOW;
                    end
                end
                default: begin
                    m_hp_cnt++;
                    if (m_hp_cnt >= hp) begin
                        m_hp_cnt = 0;
                        m_pulses++;
                        if (m_pulses < DATA_BITS + m_gain + 1) begin
                            m_phase = PH_HIGH;
                        end else begin
                            // clamp the count to 1..MAX_AVERAGE
                            n = (m_count == '0) ? 1 :
                                (m_count > MAX_AVERAGE) ? MAX_AVERAGE : m_count;
                            m_sum += longint'($signed(m_word));
                            m_reads++;
                            if (m_reads >= n) begin
                                quot    = m_sum / longint'(n);
                                m_avg   = quot[DATA_BITS-1:0];
                                r.done  = 1'b1;
                                m_phase = PH_IDLE;
                            end else begin
                                m_wait_cnt = 0;
                                m_phase    = PH_WAIT;
                            end
                        end
                    end
                end
            endcase
        end
        r.busy = (m_phase != PH_IDLE);
        r.avg  = m_avg;
        return r;
    endfunction

    function automatic logic [DATA_BITS-1:0] pick_word();
        if (word_plan.size() != 0)
            return word_plan.pop_front();
        case ($urandom_range(7))
            0:       return {1'b1, {(DATA_BITS-1){1'b0}}};
            1:       return {1'b0, {(DATA_BITS-1){1'b1}}};
            2:       return '0;
            3:       return '1;
            default: return DATA_BITS'($urandom);
        endcase
    endfunction

    // Ticks of not-ready before the converter answers; sometimes past the timeout
    function automatic int pick_wait();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (m_timeout <= 40)
            return (m_timeout == '0) ? 1 : int'(m_timeout);
        return $urandom_range(5, 20);
    endfunction

    // Send one tick beat in bursts with random gaps; predict once it is taken
    task automatic send_tick(input logic dout, input logic start);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                tick_ch.valid       <= 1'b0;
                tick_ch.dout_sample <= 1'($urandom);
                tick_ch.start_req   <= 1'($urandom);
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        tick_ch.valid       <= 1'b1;
        tick_ch.dout_sample <= dout;
        tick_ch.start_req   <= start;
        do @(posedge i_clk); while (!tick_ch.ready);
        sent_items++;
        pending_beats.push_back(serial_reader_tick(dout, start));
    endtask

    // Behave like the converter: ready after a few ticks, then the planned word
    task automatic next_tick(input bit allow_start);
        logic                         dout;
        logic                         start;
        int unsigned                  hp;
        logic [$clog2(DATA_BITS)-1:0] bit_pos;
        hp    = (m_half == '0) ? 1 : m_half;
        dout  = 1'($urandom);
        start = allow_start && ($urandom_range(99) < ((m_phase == PH_IDLE) ? 35 : 3));
        if (m_phase == PH_WAIT) begin
            if (m_wait_cnt == 0)
                wait_left = pick_wait();
            dout = (wait_left > 0);
            if ($urandom_range(99) < 3)
                dout = 1'($urandom);
            if (dout) begin
                if (wait_left > 0)
                    wait_left--;
            end else begin
                conv_word = pick_word();
            end
        end else if (m_phase == PH_HIGH && m_pulses < DATA_BITS && m_hp_cnt + 1 >= hp) begin
            bit_pos = $clog2(DATA_BITS)'(DATA_BITS - 1 - m_pulses);
            dout    = conv_word[bit_pos];
            if ($urandom_range(99) < 3)
                dout = ~dout;
        end
        send_tick(dout, start);
    endtask

    task automatic pause_until_drained();
        tick_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_beats.size() != 0);
    endtask

    task automatic run_requests(input int n);
        repeat (n) begin
            send_tick(1'($urandom), 1'b1);
            while (m_phase != PH_IDLE)
                next_tick(1'b1);
        end
    endtask

    // Finish any run, drain the results, then write one register over APB
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        while (m_phase != PH_IDLE)
            next_tick(1'b0);
        pause_until_drained();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_GAIN:    m_gain    = value[GAIN_W-1:0];
            REG_COUNT:   m_count   = value[CNT_W-1:0];
            REG_TIMEOUT: m_timeout = value[WAIT_W-1:0];
            REG_HALF:    m_half    = value[HP_W-1:0];
            REG_PDOWN:   m_pdown   = value[0];
            default:     ;
        endcase
    endtask

    task automatic test_idle_after_reset();
        repeat (6) send_tick(1'($urandom), 1'b0);
    endtask

    // Full-scale and sign-boundary words, plus truncation of negative means
    task automatic test_word_extremes();
        word_plan = '{24'h800000, 24'h7fffff};
        run_requests(2);
        write_reg(REG_COUNT, 2);
        word_plan = '{24'hfffffd, 24'h000000, 24'h800000, 24'h800000};
        run_requests(2);
        write_reg(REG_COUNT, 1);
    endtask

    task automatic test_start_while_busy();
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        while (m_phase != PH_IDLE)
            next_tick(1'b1);
    endtask

    task automatic test_timeouts();
        write_reg(REG_TIMEOUT, 0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        write_reg(REG_TIMEOUT, 1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        write_reg(REG_TIMEOUT, 5);
        run_requests(4);
        write_reg(REG_TIMEOUT, APB_DW'(TIMEOUT_RST));
    endtask

    task automatic test_power_down();
        write_reg(REG_PDOWN, 1);
        repeat (20) next_tick(1'b1);
        send_tick(1'b0, 1'b1);
        write_reg(REG_PDOWN, 0);
        run_requests(1);
    endtask

    task automatic test_gain_modes();
        for (int g = 0; g < 2**GAIN_W; g++) begin
            write_reg(REG_GAIN, g);
            run_requests(1);
        end
        write_reg(REG_GAIN, 0);
    endtask

    // Zero acts as one tick; a longer half period runs once with the most pulses
    task automatic test_half_periods();
        write_reg(REG_HALF, 0);
        run_requests(1);
        write_reg(REG_GAIN, 3);
        write_reg(REG_HALF, 3);
        run_requests(1);
        write_reg(REG_GAIN, 0);
        write_reg(REG_HALF, 1);
    endtask

    // Zero clamps to one; an odd count of readings averaged
    task automatic test_average_counts();
        write_reg(REG_COUNT, 0);
        run_requests(1);
        write_reg(REG_COUNT, 3);
        run_requests(1);
        write_reg(REG_COUNT, 1);
    endtask

    // Upper bits beyond each field and unused addresses must change nothing
    task automatic test_register_decode();
        for (int i = int'(REG_PDOWN) + 1; i < 2**REG_IDX_W; i++)
            write_reg(REG_IDX_W'(i), $urandom);
        run_requests(1);
        write_reg(REG_TIMEOUT, 32'hffff_ffff);
        write_reg(REG_GAIN, 32'hffff_fffc);
        write_reg(REG_COUNT, 32'hffff_fe01);
        write_reg(REG_HALF, 32'hffff_ff01);
        write_reg(REG_PDOWN, 32'hffff_fffe);
        run_requests(1);
    endtask

    task automatic test_random_configs();
        int seg;
        do begin
            write_reg(REG_GAIN, $urandom_range(3));
            write_reg(REG_COUNT, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4));
            write_reg(REG_TIMEOUT, ($urandom_range(3) == 0) ? int'(TIMEOUT_RST) :
                                   $urandom_range(0, 12));
            write_reg(REG_HALF, $urandom_range(3));
            write_reg(REG_PDOWN, APB_DW'($urandom_range(19) == 0));
            seg = $urandom_range(40, 120);
            repeat (seg) next_tick(1'b1);
        end while (sent_items < ITEM_TARGET);
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        write_reg(REG_PDOWN, 0);
        write_reg(REG_COUNT, 2);
        write_reg(REG_HALF, 1);
        write_reg(REG_TIMEOUT, APB_DW'(TIMEOUT_RST));
        hold_req = 1'b1;
        repeat (60) next_tick(1'b1);
        pause_until_drained();
        repeat (40) next_tick(1'b1);
    endtask

    // Receiver: hold-off on request, otherwise a stall mode that changes now and then
    initial begin
        t_rx_mode   rx_mode;
        int         mode_left;
        int         hold_cnt;
        logic [2:0] pat_pos;
        logic [7:0] rx_pattern;
        rx_mode    = RX_ALWAYS;
        mode_left  = 0;
        hold_cnt   = 0;
        pat_pos    = '0;
        rx_pattern = 8'hff;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES) begin
                    hold_cnt = 0;
                    hold_req = 1'b0;
                end
            end else begin
                if (mode_left == 0) begin
                    rx_mode    = t_rx_mode'($urandom_range(3));
                    rx_pattern = 8'($urandom_range(1, 255));
                    mode_left  = $urandom_range(16, 128);
                end
                mode_left--;
                case (rx_mode)
                    RX_ALWAYS:  res_ch.ready <= 1'b1;
                    RX_HALF:    res_ch.ready <= ($urandom_range(99) < 50);
                    RX_PATTERN: begin
                        res_ch.ready <= rx_pattern[pat_pos];
                        pat_pos = pat_pos + 3'd1;
                    end
                    default:    res_ch.ready <= ($urandom_range(99) < 85);
                endcase
            end
        end
    end

    task automatic check_field(input string field, input logic [DATA_BITS-1:0] want,
                               input logic [DATA_BITS-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endtask

    // Compare every accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_tick_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_beats.size() == 0) begin
                $display("%0t ns: unexpected result beat, expected none, actual clk %0b busy %0b",
                         $time, res_ch.clock_out, res_ch.busy_res);
                errors++;
            end else begin
                want = pending_beats.pop_front();
                check_field("clock_out", DATA_BITS'(want.clk), DATA_BITS'(res_ch.clock_out));
                check_field("busy_res", DATA_BITS'(want.busy), DATA_BITS'(res_ch.busy_res));
                check_field("done_res", DATA_BITS'(want.done), DATA_BITS'(res_ch.done_res));
                check_field("timed_out", DATA_BITS'(want.tmo), DATA_BITS'(res_ch.timed_out));
                check_field("average", want.avg, res_ch.average);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t ns: cycle limit reached, %0d beats outstanding",
                     $time, pending_beats.size());
            $display("load_cell_adc_serial_reader_top_tb: errors");
            $finish;
        end
    end

    initial begin
        errors     = 0;
        cycle_cnt  = 0;
        sent_items = 0;
        burst_left = 0;
        wait_left  = 0;
        conv_word  = '0;
        hold_req   = 1'b0;
        reset_reader_model();
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        tick_ch.valid       <= 1'b0;
        tick_ch.dout_sample <= 1'b1;
        tick_ch.start_req   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_word_extremes();
        test_start_while_busy();
        test_timeouts();
        test_power_down();
        test_gain_modes();
        test_half_periods();
        test_average_counts();
        test_register_decode();
        test_random_configs();
        test_backpressure();

        // Let the last results and any stray beat show up
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("load_cell_adc_serial_reader_top_tb: clean");
        else
            $display("load_cell_adc_serial_reader_top_tb: errors");
        $finish;
    end

endmodule

/* files.f */
sv/lcr_pkg.sv
sv/lcr_ifs.sv
sv/lcr_regs.sv
sv/lcr_ctrl.sv
sv/lcr_dpath.sv
sv/load_cell_adc_serial_reader_top.sv
tb/sv/load_cell_adc_serial_reader_top_tb.sv
